FILE: src/fwh_pkg.sv
// Package for the uniform-bin histogram fill unit.
// Operation codes, register map, defaults and the front-to-back command type.
// No dependencies.
package fwh_pkg;

  localparam int MAX_BINS_DEF   = 4096;
  localparam int COUNT_BITS_DEF = 48;
  localparam int Q_DEPTH        = 2;

  localparam logic [1:0] OP_FILL     = 2'd0;
  localparam logic [1:0] OP_READ_BIN = 2'd1;
  localparam logic [1:0] OP_READ_OOR = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [1:0] REG_LOW_EDGE  = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
  localparam logic [1:0] REG_BIN_COUNT = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic [31:0] LOW_EDGE_RST  = 32'd0;
  localparam logic [31:0] BIN_WIDTH_RST = 32'd65536;
  localparam logic [12:0] BIN_COUNT_RST = 13'd4096;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  op;      // OP_FILL, OP_READ_BIN or OP_READ_OOR
    logic        oor;     // goes to the out-of-range counter / invalid read
    logic [11:0] bin;     // bin number (0 when oor)
    logic [15:0] weight;
  } cmd_t;

endpackage

FILE: src/fwh_if.sv
// Valid/ready channel interface used for the item and result channels.
// Payload width and type are set per instance. No package dependency.
interface fwh_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/fwh_front.sv
// Front end: accepts items, divides (sample - low_edge) by bin_width with a
// restoring divider (one quotient bit per cycle) and classifies the item.
// Depends on fwh_pkg.
module fwh_front #(
  parameter int MAX_BINS = fwh_pkg::MAX_BINS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic signed [31:0] in_sample,
  input  logic [15:0]       in_weight,
  input  logic [11:0]       in_read_index,
  input  logic [31:0]       low_edge,
  input  logic [31:0]       bin_width,
  input  logic [12:0]       bin_count,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output fwh_pkg::cmd_t     cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [32:0] num_r;      // dividend shifting out, becomes quotient
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  fwh_pkg::cmd_t cmd_r;

  logic [32:0] diff;
  logic [13:0] nb;
  logic [33:0] rem_sh, trial;

  assign diff = {in_sample[31], in_sample} - {low_edge[31], low_edge};
  assign nb = (14'(bin_count) > 14'(MAX_BINS)) ? 14'(MAX_BINS) : 14'(bin_count);
  assign rem_sh = {rem_r, num_r[32]};
  assign trial  = rem_sh - {2'b0, bin_width};

  assign in_ready  = (state_r == S_IDLE);
  assign cmd_valid = (state_r == S_OUT);
  assign cmd       = cmd_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (in_operation == fwh_pkg::OP_FILL) ? S_DIV : S_OUT;
      S_DIV:   if (cnt_r == 6'd32) state_nxt = S_OUT;
      S_OUT:   if (cmd_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r.op     <= in_operation;
      cmd_r.weight <= in_weight;
      cmd_r.oor    <= (14'(in_read_index) >= nb);
      cmd_r.bin    <= (14'(in_read_index) >= nb) ? 12'd0 : in_read_index;
      // 32 dividend bits from the top; the padding bit ends up above the quotient
      num_r        <= {diff[31:0], 1'b0};
      rem_r        <= '0;
      cnt_r        <= '0;
      neg_r        <= diff[32] | (bin_width == 32'd0);
    end else if (state_r == S_DIV) begin
      if (cnt_r == 6'd32) begin
        // quotient in num_r; out of range when negative or too large
        if (neg_r || (num_r >= 33'(nb))) begin
          cmd_r.oor <= 1'b1;
          cmd_r.bin <= '0;
        end else begin
          cmd_r.oor <= 1'b0;
          cmd_r.bin <= num_r[11:0];
        end
      end else begin
        if (!trial[33]) begin
          rem_r <= trial[32:0];
          num_r <= {num_r[31:0], 1'b1};
        end else begin
          rem_r <= rem_sh[32:0];
          num_r <= {num_r[31:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end
endmodule

FILE: src/fwh_queue.sv
// Short FIFO between front and back so each side stalls on its own.
// Depends on fwh_pkg.
module fwh_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  fwh_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output fwh_pkg::cmd_t rd_data
);
  localparam int AW = $clog2(fwh_pkg::Q_DEPTH);
  fwh_pkg::cmd_t mem_r [fwh_pkg::Q_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   fill_r;
  logic          wr, rd;

  assign wr_ready = (fill_r != (AW+1)'(fwh_pkg::Q_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid & wr_ready;
  assign rd = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      fill_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      fill_r <= fill_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

FILE: src/fwh_back.sv
// Back end: bin memory with read-modify-write, out-of-range counter,
// clearing pass after reset and the registered result stage.
// Depends on fwh_pkg.
module fwh_back #(
  parameter int MAX_BINS   = fwh_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = fwh_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  fwh_pkg::cmd_t cmd,
  input  logic [47:0]   threshold,
  output logic          busy_clear,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [11:0]   out_bin_number,
  output logic          out_out_of_range,
  output logic [47:0]   out_count_value,
  output logic          out_meets_threshold
);
  localparam int AW = $clog2(MAX_BINS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [COUNT_BITS-1:0] mem_r [MAX_BINS];
  logic [COUNT_BITS-1:0] rdata_r, outside_r, newc;
  logic [2:0]    state_r, state_nxt;
  logic [AW:0]   clr_r;
  logic [AW-1:0] addr;
  fwh_pkg::cmd_t c_r;
  logic [COUNT_BITS-1:0] base, res_r;
  logic [COUNT_BITS:0]   sum;
  logic          wen;
  logic [11:0]   bin_r;
  logic          oor_r;

  assign busy_clear = (state_r == S_CLR);
  assign cmd_ready  = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign addr = (state_r == S_CLR) ? clr_r[AW-1:0] : AW'(c_r.bin);

  assign base = (c_r.op == fwh_pkg::OP_FILL && c_r.oor) ? outside_r : rdata_r;
  assign sum  = {1'b0, base} + (COUNT_BITS+1)'(c_r.weight);
  assign newc = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
  assign wen  = (state_r == S_CLR) ||
                (state_r == S_UPD && c_r.op == fwh_pkg::OP_FILL && !c_r.oor);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_r == (AW+1)'(MAX_BINS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (cmd_valid) state_nxt = S_RD;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      outside_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_UPD && c_r.op == fwh_pkg::OP_FILL && c_r.oor) outside_r <= newc;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem_r[addr] <= (state_r == S_CLR) ? '0 : newc;
    rdata_r <= mem_r[addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid) c_r <= cmd;
    if (state_r == S_UPD) begin
      bin_r <= c_r.bin;
      oor_r <= c_r.oor;
      unique case (c_r.op)
        fwh_pkg::OP_FILL:     res_r <= newc;
        fwh_pkg::OP_READ_BIN: res_r <= c_r.oor ? '0 : rdata_r;
        default: begin
          res_r <= outside_r;
          oor_r <= 1'b0;
          bin_r <= '0;
        end
      endcase
    end
  end

  assign out_bin_number   = bin_r;
  assign out_out_of_range = oor_r;
  assign out_count_value  = 48'(res_r);
  assign out_meets_threshold = (oor_r && c_r.op == fwh_pkg::OP_READ_BIN) ? 1'b0 :
                               (64'(res_r) >= 64'(threshold));
endmodule

FILE: src/fixed_width_histogram_fill_unit.sv
// Top level of the uniform-bin histogram fill unit: APB registers, front,
// queue and back. Depends on fwh_pkg, fwh_if, fwh_front, fwh_queue, fwh_back.
//
//  channel  dir  handshake          payload
//  in_      in   valid/ready        operation, sample, weight, read_index
//  out_     out  valid/ready        bin_number, out_of_range, count_value, meets_threshold
//  cfg_     in   APB, pready high   4 registers at 8*i, 64-bit data
//
// Fill: the front accepts the item, runs the divider and hands the command to the queue;
// the back end takes it, reads the bin, updates it and presents the result. The front
// takes the next item only once the queue has taken the current one. Reads skip the divider.
// After reset a clearing pass over all MAX_BINS bins runs; items wait, config writes work.
// A stalled result holds the back end; the queue lets the front keep dividing.
module fixed_width_histogram_fill_unit #(
  parameter int MAX_BINS   = fwh_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = fwh_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fwh_if.sink         in_ch,
  fwh_if.source       out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [31:0] low_edge_r, bin_width_r;
  logic [12:0] bin_count_r;
  logic [47:0] thr_r;
  logic [1:0]  ridx;
  logic        q_wv, q_wr, q_rv, q_rr, clr, in_rdy, ov;
  fwh_pkg::cmd_t q_in, q_out;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_edge_r  <= fwh_pkg::LOW_EDGE_RST;
      bin_width_r <= fwh_pkg::BIN_WIDTH_RST;
      bin_count_r <= fwh_pkg::BIN_COUNT_RST;
      thr_r       <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2:0] == 3'b000) begin
      unique case (ridx)
        fwh_pkg::REG_LOW_EDGE:  low_edge_r  <= cfg_pwdata[31:0];
        fwh_pkg::REG_BIN_WIDTH: bin_width_r <= cfg_pwdata[31:0];
        fwh_pkg::REG_BIN_COUNT: bin_count_r <= cfg_pwdata[12:0];
        default:                thr_r <= cfg_pwdata[47:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      fwh_pkg::REG_LOW_EDGE:  cfg_prdata = {32'd0, low_edge_r};
      fwh_pkg::REG_BIN_WIDTH: cfg_prdata = {32'd0, bin_width_r};
      fwh_pkg::REG_BIN_COUNT: cfg_prdata = {51'd0, bin_count_r};
      default:                cfg_prdata = {16'd0, thr_r};
    endcase
  end

  assign in_ch.ready = in_rdy & ~clr;

  fwh_front #(.MAX_BINS(MAX_BINS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid & ~clr & (in_ch.data.operation != fwh_pkg::OP_UNUSED)),
    .in_ready(in_rdy),
    .in_operation(in_ch.data.operation), .in_sample(in_ch.data.sample),
    .in_weight(in_ch.data.weight), .in_read_index(in_ch.data.read_index),
    .low_edge(low_edge_r), .bin_width(bin_width_r), .bin_count(bin_count_r),
    .cmd_valid(q_wv), .cmd_ready(q_wr), .cmd(q_in)
  );

  fwh_queue u_queue (
    .clk, .rst_n, .wr_valid(q_wv), .wr_ready(q_wr), .wr_data(q_in),
    .rd_valid(q_rv), .rd_ready(q_rr), .rd_data(q_out)
  );

  fwh_back #(.MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .cmd_valid(q_rv), .cmd_ready(q_rr), .cmd(q_out),
    .threshold(thr_r), .busy_clear(clr),
    .out_valid(ov), .out_ready(out_ch.ready),
    .out_bin_number(out_ch.data.bin_number), .out_out_of_range(out_ch.data.out_of_range),
    .out_count_value(out_ch.data.count_value),
    .out_meets_threshold(out_ch.data.meets_threshold)
  );
  assign out_ch.valid = ov;
endmodule

FILE: dv/fwh_tb_pkg.sv
// Channel payload types for the histogram fill unit testbench.
// No dependencies.
package fwh_tb_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] sample;
    logic [15:0] weight;
    logic [11:0] read_index;
  } hist_item_t;

  typedef struct packed {
    logic [11:0] bin_number;
    logic        out_of_range;
    logic [47:0] count_value;
    logic        meets_threshold;
  } hist_result_t;

endpackage

FILE: dv/fwh_checker.sv
// Passive checker: tracks register writes, predicts each result of the
// histogram unit and compares it with what leaves the out channel.
// Depends on fwh_pkg and fwh_tb_pkg.
module fwh_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  fwh_tb_pkg::hist_item_t   in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  fwh_tb_pkg::hist_result_t out_data,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);
  import fwh_pkg::*;
  import fwh_tb_pkg::*;

  localparam logic [47:0] CNT_MAX = '1;

  logic signed [31:0] low_edge;
  logic [31:0]        bin_width;
  logic [12:0]        bin_count;
  logic [47:0]        threshold;
  logic [47:0]        bin_counts [MAX_BINS_DEF];
  logic [47:0]        outside_count;
  hist_result_t       expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [47:0] sat_sum(logic [47:0] c, logic [15:0] w);
    logic [48:0] s;
    s = {1'b0, c} + w;
    return s[48] ? CNT_MAX : s[47:0];
  endfunction

  // returns 1 when the item produces a result
  function automatic bit bin_item(hist_item_t it, output hist_result_t r);
    longint signed   diff;
    longint unsigned q, nb;
    nb = (bin_count > MAX_BINS_DEF) ? MAX_BINS_DEF : bin_count;
    r = '0;
    case (it.operation)
      OP_FILL: begin
        diff = longint'($signed(it.sample)) - longint'(low_edge);
        q = nb;
        if (diff >= 0 && bin_width != 0) q = longint'(diff) / longint'(bin_width);
        if (q < nb) begin
          bin_counts[q] = sat_sum(bin_counts[q], it.weight);
          r.bin_number = q[11:0];
          r.count_value = bin_counts[q];
        end else begin
          outside_count = sat_sum(outside_count, it.weight);
          r.out_of_range = 1'b1;
          r.count_value = outside_count;
        end
        r.meets_threshold = r.count_value >= threshold;
        return 1;
      end
      OP_READ_BIN: begin
        if (it.read_index < nb) begin
          r.bin_number = it.read_index;
          r.count_value = bin_counts[it.read_index];
          r.meets_threshold = r.count_value >= threshold;
        end else r.out_of_range = 1'b1;
        return 1;
      end
      OP_READ_OOR: begin
        r.count_value = outside_count;
        r.meets_threshold = outside_count >= threshold;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    hist_result_t r, e;
    if (!rst_n) begin
      low_edge <= LOW_EDGE_RST;
      bin_width <= BIN_WIDTH_RST;
      bin_count <= BIN_COUNT_RST;
      threshold <= '0;
      outside_count = '0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_LOW_EDGE:  low_edge <= cfg_pwdata[31:0];
          REG_BIN_WIDTH: bin_width <= cfg_pwdata[31:0];
          REG_BIN_COUNT: bin_count <= cfg_pwdata[12:0];
          REG_THRESHOLD: threshold <= cfg_pwdata[47:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready && bin_item(in_data, r)) expected_results.push_back(r);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_data !== e) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/testbench.sv
// Top of the histogram fill unit testbench: clock, reset, register phases,
// item stimulus and verdict. Depends on fwh_pkg, fwh_tb_pkg, fwh_if, fwh_checker.
module testbench;
  import fwh_pkg::*;
  import fwh_tb_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic        clk, rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending;
  int          cycles = 0;
  idle_mode_e  idle_mode;
  logic [31:0] cur_low, cur_width;
  logic [12:0] cur_count;

  fwh_if #(.payload_t(hist_item_t))   in_ch  (clk);
  fwh_if #(.payload_t(hist_result_t)) out_ch (clk);

  fixed_width_histogram_fill_unit i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  fwh_checker i_checker (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fixed_width_histogram_fill_unit");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk)
    out_ch.ready = !((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 69) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(99) < 11));

  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = {idx, 3'b000}; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0;
    case (idx)
      REG_LOW_EDGE:  cur_low = value[31:0];
      REG_BIN_WIDTH: cur_width = value[31:0];
      REG_BIN_COUNT: cur_count = value[12:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] lo, logic [31:0] wd, logic [12:0] nb,
                       logic [47:0] thr, idle_mode_e mode);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    reg_write(REG_LOW_EDGE, {32'd0, lo});
    reg_write(REG_BIN_WIDTH, {32'd0, wd});
    reg_write(REG_BIN_COUNT, {51'd0, nb});
    reg_write(REG_THRESHOLD, {16'd0, thr});
    idle_mode = mode;
  endtask

  // called at a falling edge; ready only moves at rising edges
  task automatic send(hist_item_t it);
    while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 69) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 11)) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    while (!in_ch.ready) @(negedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] s, logic [15:0] w, logic [11:0] idx);
    hist_item_t it;
    it.operation = op; it.sample = s; it.weight = w; it.read_index = idx;
    send(it);
  endtask

  // mostly samples that land near the configured bins, some fully random
  task automatic random_items(int n);
    hist_item_t      it;
    longint unsigned span, off;
    longint signed   s;
    int              nb;
    for (int k = 0; k < n; k++) begin
      it = hist_item_t'(62'({$urandom, $urandom}));
      nb = (cur_count > MAX_BINS_DEF) ? MAX_BINS_DEF : cur_count;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          it.operation = OP_FILL;
          if ($urandom_range(3) != 0) begin
            span = longint'(cur_width) * (nb + 2) + 1;
            off = {$urandom, $urandom} % span;
            s = longint'($signed(cur_low)) + longint'(off) -
                longint'($urandom_range(cur_width > 4 ? 4 : cur_width));
            it.sample = s[31:0];
          end
        end
        6, 7: begin
          it.operation = OP_READ_BIN;
          if ($urandom_range(3) != 0 && nb > 0) it.read_index = 12'($urandom_range(nb + 1));
        end
        8: it.operation = OP_READ_OOR;
        default: ;
      endcase
      send(it);
    end
  endtask

  initial begin
    rst_n = 1'b0; idle_mode = IDLE_NONE;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    cur_low = LOW_EDGE_RST; cur_width = BIN_WIDTH_RST; cur_count = BIN_COUNT_RST;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: edges of the bin range, weights, reads, unused op
    send_op(OP_FILL, 32'h0000_0000, 16'hFFFF, 12'h000);
    send_op(OP_FILL, 32'h0000_FFFF, 16'h0000, 12'hFFF);
    send_op(OP_FILL, 32'hFFFF_FFFF, 16'h0007, 12'h000);
    send_op(OP_FILL, 32'h8000_0000, 16'h0001, 12'h000);
    send_op(OP_FILL, 32'h0FFF_FFFF, 16'h1234, 12'h000);
    send_op(OP_FILL, 32'h1000_0000, 16'h0002, 12'h000);
    send_op(OP_FILL, 32'h7FFF_FFFF, 16'hFFFF, 12'h000);
    send_op(OP_READ_BIN, 32'hFFFF_FFFF, 16'hFFFF, 12'h000);
    send_op(OP_READ_BIN, 32'h0, 16'h0, 12'hFFF);
    send_op(OP_UNUSED, 32'h0000_0000, 16'h5555, 12'h000);
    send_op(OP_READ_OOR, 32'h0, 16'h0, 12'h000);
    random_items(190);

    setup(32'h8000_0000, 32'd1, 13'h1FFF, 48'hFFFF_FFFF_FFFF, IDLE_SENDER);
    send_op(OP_FILL, 32'h8000_0FFF, 16'd9, 12'h000);
    send_op(OP_FILL, 32'h8000_1000, 16'd9, 12'h000);
    send_op(OP_READ_BIN, 32'h0, 16'h0, 12'hFFF);
    random_items(190);

    setup(32'h7FFF_FFFF, 32'hFFFF_FFFF, 13'd1, 48'd5, IDLE_RECEIVER);
    send_op(OP_FILL, 32'h7FFF_FFFF, 16'd3, 12'h000);
    send_op(OP_READ_BIN, 32'h0, 16'h0, 12'd1);
    random_items(190);

    // zero width, then zero bins: everything lands outside
    setup(32'h0, 32'd0, 13'd16, 48'd100000, IDLE_BOTH);
    random_items(100);
    setup(32'h0, 32'd65536, 13'd0, 48'd0, IDLE_BOTH);
    send_op(OP_READ_BIN, 32'h0, 16'h0, 12'h000);
    random_items(100);

    setup($urandom, $urandom_range(1, 1 << 20), 13'd16, 48'd100, IDLE_NONE);
    random_items(200);
    setup(-(32'sd50 <<< 16), 32'd3 << 16, 13'd4096,
          48'({$urandom_range(3), $urandom}), IDLE_SENDER);
    random_items(200);
    setup($urandom, $urandom_range(1, 1 << 16), 13'd100, 48'd1000, IDLE_RECEIVER);
    random_items(200);

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS fixed_width_histogram_fill_unit");
    end else begin
      $display("FAIL fixed_width_histogram_fill_unit");
    end
    $finish;
  end
endmodule
